@@ rtl/mdi_pkg.sv @@
// Shared types and constants for the max degree imbalance block.
// No dependencies.
`default_nettype none

package mdi_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int BALANCE_BITS_DEF = 16;

    localparam int VTX_W      = 8;
    localparam int NV_W       = 9;
    localparam int DIFF_W     = 15;
    localparam int DIFF_LIMIT = 32767;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 16;

    typedef enum logic [0:0] {
        CMD_EDGE   = 1'b0,
        CMD_FINISH = 1'b1
    } cmd_t;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic             edge_en;
        logic             shift_en;
        logic [VTX_W-1:0] src;
        logic [VTX_W-1:0] dst;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/mdi_cell.sv @@
// One vertex balance cell of the row: saturating +1/-1 update per edge,
// shift toward cell 0 during a scan. Depends on mdi_pkg.
`default_nettype none

module mdi_cell #(
    parameter int INDEX        = 0,
    parameter int BALANCE_BITS = mdi_pkg::BALANCE_BITS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  mdi_pkg::cell_ctrl_t              ctrl,
    input  wire logic signed [BALANCE_BITS-1:0] shift_in,
    output logic signed [BALANCE_BITS-1:0]   bal
);

    localparam logic signed [BALANCE_BITS-1:0] BAL_MAX = {1'b0, {(BALANCE_BITS-1){1'b1}}};
    localparam logic signed [BALANCE_BITS-1:0] BAL_MIN = {1'b1, {(BALANCE_BITS-1){1'b0}}};

    logic signed [BALANCE_BITS-1:0] bal_reg;
    logic signed [BALANCE_BITS-1:0] bal_next;
    logic                           inc;
    logic                           dec;

    assign inc = ctrl.edge_en && (32'(ctrl.src) == 32'(INDEX));
    assign dec = ctrl.edge_en && (32'(ctrl.dst) == 32'(INDEX));

    always_comb
    begin
        bal_next = bal_reg;
        if (ctrl.shift_en)
        begin
            bal_next = shift_in;
        end
        else if (inc && (bal_reg != BAL_MAX))
        begin
            bal_next = bal_reg + BALANCE_BITS'(1);
        end
        else if (dec && (bal_reg != BAL_MIN))
        begin
            bal_next = bal_reg - BALANCE_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bal_reg <= '0;
        end
        else
        begin
            bal_reg <= bal_next;
        end
    end

    assign bal = bal_reg;

endmodule

`default_nettype wire

@@ rtl/mdi_ctrl.sv @@
// Controller: input/output handshakes, config register, edge decode and the
// scan head that folds the shifted-out balances into a running max. Depends on mdi_pkg.
`default_nettype none

module mdi_ctrl #(
    parameter int MAX_VERTICES = mdi_pkg::MAX_VERTICES_DEF,
    parameter int BALANCE_BITS = mdi_pkg::BALANCE_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire [mdi_pkg::S_DATA_W-1:0]          s_tdata,
    input  wire                                  s_tuser,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [mdi_pkg::M_DATA_W-1:0]         m_tdata,
    output logic                                 m_tuser,
    input  wire                                  cfg_we,
    input  wire [mdi_pkg::NV_W-1:0]              cfg_wdata,
    input  wire logic signed [BALANCE_BITS-1:0]  head_bal,
    output mdi_pkg::cell_ctrl_t                  ctrl
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_VERTICES);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [mdi_pkg::DIFF_W-1:0]    max_reg, max_next;
    logic [mdi_pkg::NV_W-1:0]      nv_reg, nv_next;
    logic                          out_valid_reg, out_valid_next;
    logic [mdi_pkg::DIFF_W-1:0]    out_max_reg, out_max_next;
    logic                          out_empty_reg, out_empty_next;

    logic [mdi_pkg::VTX_W-1:0]     src;
    logic [mdi_pkg::VTX_W-1:0]     dst;
    logic                          accept;
    logic                          out_free;
    logic                          in_limit;
    logic [BALANCE_BITS-1:0]       mag;
    logic [31:0]                   mag32;
    logic [mdi_pkg::DIFF_W-1:0]    cur_abs;

    assign src      = s_tdata[mdi_pkg::VTX_W-1:0];
    assign dst      = s_tdata[2*mdi_pkg::VTX_W-1:mdi_pkg::VTX_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign mag     = head_bal[BALANCE_BITS-1] ? (~head_bal + BALANCE_BITS'(1)) : head_bal;
    assign mag32   = 32'(mag);
    assign cur_abs = (mag32 > 32'(mdi_pkg::DIFF_LIMIT)) ? mdi_pkg::DIFF_W'(mdi_pkg::DIFF_LIMIT)
                                                        : mag32[mdi_pkg::DIFF_W-1:0];
    assign in_limit = (32'(cnt_reg) < 32'(nv_reg));

    always_comb
    begin
        ctrl.edge_en  = accept && (s_tuser == mdi_pkg::CMD_EDGE) && (src != dst)
                        && (32'(src) < 32'(MAX_VERTICES)) && (32'(dst) < 32'(MAX_VERTICES));
        ctrl.shift_en = 1'b0;
        ctrl.src      = src;
        ctrl.dst      = dst;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        max_next       = max_reg;
        nv_next        = cfg_we ? cfg_wdata : nv_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_max_next   = out_max_reg;
        out_empty_next = out_empty_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tuser == mdi_pkg::CMD_FINISH))
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                    max_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg != CNT_END)
                begin
                    ctrl.shift_en = 1'b1;
                    cnt_next      = cnt_reg + CNT_W'(1);
                    if (in_limit && (cur_abs > max_reg))
                    begin
                        max_next = cur_abs;
                    end
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_max_next   = max_reg;
                    out_empty_next = (nv_reg == '0);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            max_reg       <= '0;
            nv_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_max_reg   <= '0;
            out_empty_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            max_reg       <= max_next;
            nv_reg        <= nv_next;
            out_valid_reg <= out_valid_next;
            out_max_reg   <= out_max_next;
            out_empty_reg <= out_empty_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = mdi_pkg::M_DATA_W'(out_max_reg);
    assign m_tuser  = out_empty_reg;

`ifndef ASSERT_OFF
    a_result_from_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_SCAN && cnt_reg == CNT_END))
        else $error("result beat without a completed scan");

    a_empty_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("empty result carries nonzero max");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_END)
        else $error("scan counter past end of row");

    a_finish_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == mdi_pkg::CMD_FINISH) |=> (state_reg == ST_SCAN && cnt_reg == '0))
        else $error("finish beat did not start a scan");

    a_no_edge_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.shift_en |-> !ctrl.edge_en)
        else $error("edge update during scan shift");
`endif

endmodule

`default_nettype wire

@@ rtl/max_degree_imbalance.sv @@
// Top level of the max degree imbalance block: controller plus a row of
// balance cells. Depends on mdi_pkg, mdi_ctrl, mdi_cell.
`default_nettype none

// Each vertex balance lives in its own cell; edges update the two matching
// cells together, so an edge beat is taken every cycle except during a scan.
// A finish beat shifts the whole row toward cell 0, one cell per cycle, where
// the controller folds each shifted-out balance into the running max while
// zeros enter at the far end: the finish waits for any previous result to
// drain and leaves the table cleared. The table is cleared at reset
// directly, with no clearing pass. The result is held in an output
// register, so edges are taken while it waits.
module max_degree_imbalance #(
    parameter int MAX_VERTICES = mdi_pkg::MAX_VERTICES_DEF,
    parameter int BALANCE_BITS = mdi_pkg::BALANCE_BITS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire [mdi_pkg::S_DATA_W-1:0]  s_tdata,   // src_vertex[7:0], dst_vertex[15:8]
    input  wire                          s_tuser,   // cmd
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [mdi_pkg::M_DATA_W-1:0] m_tdata,   // peak_imbalance[14:0], zero[15]
    output logic                         m_tuser,   // empty_res
    input  wire                          cfg_we,
    input  wire [mdi_pkg::NV_W-1:0]      cfg_wdata  // num_vertices
);

    mdi_pkg::cell_ctrl_t         ctrl;
    logic signed [BALANCE_BITS-1:0] bal_row [MAX_VERTICES];

    mdi_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .BALANCE_BITS (BALANCE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .head_bal  (bal_row[0]),
        .ctrl      (ctrl)
    );

    for (genvar i = 0; i < MAX_VERTICES; i++)
    begin : g_cell
        logic signed [BALANCE_BITS-1:0] shift_in;

        if (i == MAX_VERTICES - 1)
        begin : g_tail
            assign shift_in = '0;
        end
        else
        begin : g_body
            assign shift_in = bal_row[i+1];
        end

        mdi_cell #(
            .INDEX        (i),
            .BALANCE_BITS (BALANCE_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .shift_in (shift_in),
            .bal      (bal_row[i])
        );
    end

endmodule

`default_nettype wire

@@ dv/tb_max_degree_imbalance.sv @@
`timescale 1ns / 100ps
// Testbench for max_degree_imbalance: streams edge and finish beats and keeps
// its own balance table to predict each report. Needs mdi_pkg and the block's RTL.
module tb_max_degree_imbalance;

    localparam int TABLE_SIZE    = mdi_pkg::MAX_VERTICES_DEF;
    localparam int BAL_W         = mdi_pkg::BALANCE_BITS_DEF;
    localparam int VTX_W         = mdi_pkg::VTX_W;
    localparam int NV_W          = mdi_pkg::NV_W;
    localparam int DIFF_W        = mdi_pkg::DIFF_W;
    localparam int DIFF_LIMIT    = mdi_pkg::DIFF_LIMIT;
    localparam int S_DATA_W      = mdi_pkg::S_DATA_W;
    localparam int M_DATA_W      = mdi_pkg::M_DATA_W;
    localparam int SETTLE_CYCLES = mdi_pkg::MAX_VERTICES_DEF + 40;
    localparam int HOLD_CYCLES   = 1500;
    localparam int RANDOM_ITEMS  = 1050;
    localparam int HEAVY_EDGES   = 100;
    localparam int NV_MAX        = (1 << NV_W) - 1;
    localparam logic signed [BAL_W-1:0] BAL_MAX = {1'b0, {(BAL_W-1){1'b1}}};
    localparam logic signed [BAL_W-1:0] BAL_MIN = {1'b1, {(BAL_W-1){1'b0}}};

    typedef struct packed {
        logic [DIFF_W-1:0] peak_imbalance;
        logic              empty_res;
    } report_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // src_vertex[7:0], dst_vertex[15:8]
    logic                s_tuser;   // cmd
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // peak_imbalance[14:0], zero[15]
    logic                m_tuser;   // empty_res
    logic                cfg_we;
    logic [NV_W-1:0]     cfg_wdata;

    logic signed [BAL_W-1:0] balance [TABLE_SIZE];
    logic [NV_W-1:0]         vertex_count;
    report_t                 pending_reports [$];
    bit                      no_idle;
    bit                      hold_req;
    int                      hold_left;
    int                      ready_gap;
    int                      errors;
    int                      beats_sent;
    int                      reports_seen;

    always #1 clk = ~clk;

    max_degree_imbalance dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [BAL_W-1:0] saturate_step(logic signed [BAL_W-1:0] b,
                                                              bit up);
        if (up)
            return (b == BAL_MAX) ? b : b + BAL_W'(1);
        return (b == BAL_MIN) ? b : b - BAL_W'(1);
    endfunction

    function automatic report_t scan_balances();
        report_t r;
        int      limit;
        int      mag;
        int      peak;
        limit = (vertex_count > TABLE_SIZE) ? TABLE_SIZE : vertex_count;
        peak  = 0;
        for (int i = 0; i < limit; i++)
        begin
            mag = (balance[i] < 0) ? -int'(balance[i]) : int'(balance[i]);
            if (mag > DIFF_LIMIT)
                mag = DIFF_LIMIT;
            if (mag > peak)
                peak = mag;
        end
        r.peak_imbalance = peak[DIFF_W-1:0];
        r.empty_res      = (vertex_count == 0);
        return r;
    endfunction

    function automatic void apply_beat(mdi_pkg::cmd_t c, logic [VTX_W-1:0] src,
                                       logic [VTX_W-1:0] dst);
        if (c == mdi_pkg::CMD_FINISH)
        begin
            pending_reports.push_back(scan_balances());
            foreach (balance[i])
                balance[i] = '0;
        end
        else if (src != dst)
        begin
            balance[src] = saturate_step(balance[src], 1'b1);
            balance[dst] = saturate_step(balance[dst], 1'b0);
        end
    endfunction

    function automatic logic [NV_W-1:0] pick_vertices();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return NV_W'(1);
        if (r < 4)
            return NV_W'(TABLE_SIZE);
        if (r == 4)
            return NV_W'($urandom_range(TABLE_SIZE + 1, NV_MAX));
        return NV_W'($urandom_range(1, TABLE_SIZE));
    endfunction

    task automatic send_beat(mdi_pkg::cmd_t c, logic [VTX_W-1:0] src, logic [VTX_W-1:0] dst);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {dst, src};
        do
            @(posedge clk);
        while (!s_tready);
        apply_beat(c, src, dst);
        beats_sent++;
    endtask

    task automatic send_edge(logic [VTX_W-1:0] src, logic [VTX_W-1:0] dst);
        send_beat(mdi_pkg::CMD_EDGE, src, dst);
    endtask

    // vertex fields are don't-care on finish, so they carry noise
    task automatic send_finish();
        send_beat(mdi_pkg::CMD_FINISH, VTX_W'($urandom), VTX_W'($urandom));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_vertices(logic [NV_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we       <= 1'b0;
        vertex_count  = v;
    endtask

    // reset leaves num_vertices at zero: empty report, table still cleared
    task automatic test_empty_graph();
        send_edge(1, 2);
        send_finish();
        set_vertices(TABLE_SIZE);
        send_finish();
    endtask

    task automatic test_field_extremes();
        send_edge(8'hFF, 8'h00);
        send_edge(8'hFF, 8'h00);
        send_edge(8'hAA, 8'h55);
        send_edge(3, 3);
        send_edge(0, 128);
        send_finish();
        send_finish();
    endtask

    task automatic test_scan_bounds();
        set_vertices(1);
        send_edge(0, 200);
        repeat (3) send_edge(9, 5);
        send_finish();
        set_vertices(TABLE_SIZE);
        send_finish();
        set_vertices(NV_MAX);
        repeat (3) send_edge(8'hFF, 8'hFE);
        send_finish();
    endtask

    // pile large balances of both signs onto two vertices, then back off a little
    task automatic test_heavy_vertex();
        set_vertices(3);
        no_idle = 1'b1;
        repeat (HEAVY_EDGES) send_edge(2, 1);
        repeat (5) send_edge(1, 2);
        send_finish();
        repeat (HEAVY_EDGES) send_edge(1, 2);
        send_finish();
        no_idle = 1'b0;
    endtask

    task automatic test_output_stall();
        set_vertices(TABLE_SIZE);
        no_idle  = 1'b1;
        hold_req = 1'b1;
        repeat (3)
        begin
            repeat (12) send_edge(VTX_W'($urandom), VTX_W'($urandom));
            send_finish();
        end
        no_idle = 1'b0;
        drain();
    endtask

    task automatic test_random_graphs();
        int               start;
        int               span;
        int               hot;
        int               base;
        int               mode;
        logic [VTX_W-1:0] src;
        logic [VTX_W-1:0] dst;
        start = beats_sent;
        while (beats_sent - start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
                set_vertices(pick_vertices());
            no_idle = ($urandom_range(0, 4) == 0);
            span = (vertex_count == 0 || vertex_count > TABLE_SIZE) ? TABLE_SIZE
                                                                     : vertex_count;
            hot  = $urandom_range(1, (span < 4) ? span : 4);
            base = $urandom_range(0, span - hot);
            repeat ($urandom_range(0, 60))
            begin
                mode = $urandom_range(0, 9);
                if (mode < 5)
                begin
                    // a few hot vertices so balances build up
                    src = VTX_W'(base + $urandom_range(0, hot - 1));
                    dst = VTX_W'($urandom_range(0, span - 1));
                    if (mode < 2)
                        {src, dst} = {dst, src};
                end
                else if (mode < 8)
                begin
                    src = VTX_W'($urandom_range(0, span - 1));
                    dst = VTX_W'($urandom_range(0, span - 1));
                end
                else
                begin
                    src = VTX_W'($urandom);
                    dst = (mode == 9) ? src : VTX_W'($urandom);
                end
                send_edge(src, dst);
            end
            send_finish();
            if ($urandom_range(0, 9) == 0)
                send_finish();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin : report_sink
        report_t want;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                reports_seen++;
                if (pending_reports.size() == 0)
                begin
                    $error("report with none pending: peak_imbalance %0d empty_res %0b",
                           m_tdata[DIFF_W-1:0], m_tuser);
                    errors++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (m_tdata[DIFF_W-1:0] !== want.peak_imbalance)
                    begin
                        $error("peak_imbalance: expected %0d, actual %0d",
                               want.peak_imbalance, m_tdata[DIFF_W-1:0]);
                        errors++;
                    end
                    if (m_tuser !== want.empty_res)
                    begin
                        $error("empty_res: expected %0b, actual %0b", want.empty_res, m_tuser);
                        errors++;
                    end
                end
            end
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (ready_gap > 0)
            begin
                ready_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready  <= 1'b1;
                ready_gap  = idle_len();
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= mdi_pkg::CMD_EDGE;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        vertex_count = '0;
        foreach (balance[i])
            balance[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_graph();
        test_field_extremes();
        test_scan_bounds();
        test_heavy_vertex();
        test_output_stall();
        test_random_graphs();
        drain();

        if (pending_reports.size() != 0)
        begin
            $error("%0d reports never arrived", pending_reports.size());
            errors++;
        end
        $display("%0d beats sent, %0d reports checked", beats_sent, reports_seen);
        $display("covered: empty graphs, scan bounds, heavy vertices, output hold-off");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ max_degree_imbalance.f @@
rtl/mdi_pkg.sv
rtl/mdi_cell.sv
rtl/mdi_ctrl.sv
rtl/max_degree_imbalance.sv
dv/tb_max_degree_imbalance.sv
